// ----- design/vwta_pkg.sv -----
// Shared types and constants for the vertex weld triangle append core.
`default_nettype none

package vwta_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int CORNERS          = 3;
	localparam int COORD_W          = 16;
	localparam int WELD_W           = 34;
	localparam int IDX_OUT_W        = 10;
	localparam int CNT_OUT_W        = 11;

	localparam logic [WELD_W-1:0] WELD_RESET = 34'd256;
	localparam logic              KIND_CLEAR = 1'b1;

	typedef struct packed {
		logic                      kind;
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by_coord;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} in_beat_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0]      index_a;
		logic [IDX_OUT_W-1:0]      index_b;
		logic [IDX_OUT_W-1:0]      index_c;
		logic                      accepted;
		logic [CNT_OUT_W-1:0]      vertex_count;
		logic                      box_valid;
		logic signed [COORD_W-1:0] box_min_x;
		logic signed [COORD_W-1:0] box_min_y;
		logic signed [COORD_W-1:0] box_max_x;
		logic signed [COORD_W-1:0] box_max_y;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

// ----- design/vertex_weld_triangle_append_core.sv -----
// Vertex weld triangle append core: nearest-vertex scan over a vertex RAM.
// Per corner: one RAM read a cycle over the N stored vertices (N = stored count then)
// into a three-stage distance pipeline, drained before the decision; a first corner on an
// empty store skips the scan. Clear or capacity refusal goes straight to the finish state.
// Throughput: one beat at a time; start is taken from the done cycle on; done cannot stall.
// Reset clears count and box and sets the threshold to 256; the vertex RAM is not cleared.
`default_nettype none

module vertex_weld_triangle_append_core #(
	parameter int MAX_VERTICES = vwta_pkg::MAX_VERTICES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  vwta_pkg::in_beat_t           cmd,
	output logic                         done,
	output vwta_pkg::out_beat_t          result,
	input  wire                          cfg_we,
	input  wire [vwta_pkg::WELD_W-1:0]   cfg_data
);

	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int CW    = vwta_pkg::COORD_W;
	localparam int WW    = vwta_pkg::WELD_W;

	vwta_pkg::state_t state_q, state_d;

	logic [WW-1:0]        weld_q;
	logic [CNT_W-1:0]     count_q;
	logic                 box_valid_q;
	logic signed [CW-1:0] bmin_x_q, bmin_y_q, bmax_x_q, bmax_y_q;
	vwta_pkg::in_beat_t   cmd_q;
	logic [1:0]           corner_q;
	logic [IDX_W-1:0]     scan_i_q;
	logic [IDX_W-1:0]     idx_q [vwta_pkg::CORNERS];
	logic                 acc_q;
	logic [WW-1:0]        best_d_q;
	logic [IDX_W-1:0]     best_q;

	logic [2*CW-1:0]      mem [MAX_VERTICES];
	logic [2*CW-1:0]      rdata_s1;
	logic                 valid_s1, valid_s2;
	logic [IDX_W-1:0]     idx_s1, idx_s2;
	logic [2*CW:0]        sqx_s2, sqy_s2;

	logic                 accept, fits, weld, rd_en, wr_en, last_issue;
	logic [CNT_W:0]       need;
	logic signed [CW-1:0] cur_x, cur_y;
	logic signed [CW:0]   dx, dy;
	logic signed [2*CW+1:0] sqx_full, sqy_full;
	logic [WW-1:0]        dsum;
	logic [IDX_W-1:0]     new_idx;

	assign accept     = start && !busy;
	assign need       = {1'b0, count_q} + (CNT_W+1)'(vwta_pkg::CORNERS);
	assign fits       = need < (CNT_W+1)'(MAX_VERTICES);
	assign last_issue = (CNT_W'(scan_i_q) + CNT_W'(1)) == count_q;
	assign weld       = (count_q != '0) && (best_d_q < weld_q);
	assign new_idx    = weld ? best_q : count_q[IDX_W-1:0];

	always_comb begin
		case (corner_q)
			2'd0: begin
				cur_x = cmd_q.ax;
				cur_y = cmd_q.ay;
			end
			2'd1: begin
				cur_x = cmd_q.bx;
				cur_y = cmd_q.by_coord;
			end
			default: begin
				cur_x = cmd_q.cx;
				cur_y = cmd_q.cy;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vwta_pkg::ST_IDLE: begin
				if (start) begin
					if (cmd.kind == vwta_pkg::KIND_CLEAR || !fits)
						state_d = vwta_pkg::ST_FINISH;
					else if (count_q == '0)
						state_d = vwta_pkg::ST_DECIDE;
					else
						state_d = vwta_pkg::ST_SCAN;
				end
			end
			vwta_pkg::ST_SCAN: begin
				if (last_issue)
					state_d = vwta_pkg::ST_DRAIN;
			end
			vwta_pkg::ST_DRAIN: begin
				if (!valid_s1 && !valid_s2)
					state_d = vwta_pkg::ST_DECIDE;
			end
			vwta_pkg::ST_DECIDE: begin
				if (corner_q == 2'(vwta_pkg::CORNERS - 1))
					state_d = vwta_pkg::ST_FINISH;
				else
					state_d = vwta_pkg::ST_SCAN;
			end
			vwta_pkg::ST_FINISH: state_d = vwta_pkg::ST_IDLE;
			default:             state_d = vwta_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy  = 1'b1;
		rd_en = 1'b0;
		wr_en = 1'b0;
		case (state_q)
			vwta_pkg::ST_IDLE:   busy  = 1'b0;
			vwta_pkg::ST_SCAN:   rd_en = 1'b1;
			vwta_pkg::ST_DECIDE: wr_en = !weld;
			default: begin
				busy  = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= vwta_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// vertex RAM, x in the low half
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[count_q[IDX_W-1:0]] <= {cur_y, cur_x};
		if (rd_en)
			rdata_s1 <= mem[scan_i_q];
	end

	// distance pipeline
	assign dx       = (CW+1)'(cur_x) - (CW+1)'(signed'(rdata_s1[CW-1:0]));
	assign dy       = (CW+1)'(cur_y) - (CW+1)'(signed'(rdata_s1[2*CW-1:CW]));
	assign sqx_full = dx * dx;
	assign sqy_full = dy * dy;
	assign dsum     = WW'(sqx_s2) + WW'(sqy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_i_q;
		idx_s2 <= idx_s1;
		sqx_s2 <= sqx_full[2*CW:0];
		sqy_s2 <= sqy_full[2*CW:0];
		if (valid_s2 && (idx_s2 == '0 || dsum < best_d_q)) begin
			best_d_q <= dsum;
			best_q   <= idx_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weld_q      <= vwta_pkg::WELD_RESET;
			count_q     <= '0;
			box_valid_q <= 1'b0;
			bmin_x_q    <= '0;
			bmin_y_q    <= '0;
			bmax_x_q    <= '0;
			bmax_y_q    <= '0;
			corner_q    <= '0;
			scan_i_q    <= '0;
			acc_q       <= 1'b0;
			done        <= 1'b0;
			result      <= '0;
			for (int k = 0; k < vwta_pkg::CORNERS; k++)
				idx_q[k] <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we)
				weld_q <= cfg_data;
			case (state_q)
				vwta_pkg::ST_IDLE: begin
					if (start) begin
						corner_q <= '0;
						scan_i_q <= '0;
						for (int k = 0; k < vwta_pkg::CORNERS; k++)
							idx_q[k] <= '0;
						acc_q <= (cmd.kind == vwta_pkg::KIND_CLEAR) || fits;
						if (cmd.kind == vwta_pkg::KIND_CLEAR) begin
							count_q     <= '0;
							box_valid_q <= 1'b0;
							bmin_x_q    <= '0;
							bmin_y_q    <= '0;
							bmax_x_q    <= '0;
							bmax_y_q    <= '0;
						end
					end
				end
				vwta_pkg::ST_SCAN: scan_i_q <= scan_i_q + IDX_W'(1);
				vwta_pkg::ST_DECIDE: begin
					idx_q[corner_q] <= new_idx;
					corner_q        <= corner_q + 2'd1;
					scan_i_q        <= '0;
					if (!weld) begin
						count_q <= count_q + CNT_W'(1);
						if (!box_valid_q) begin
							box_valid_q <= 1'b1;
							bmin_x_q    <= cur_x;
							bmax_x_q    <= cur_x;
							bmin_y_q    <= cur_y;
							bmax_y_q    <= cur_y;
						end else begin
							if (cur_x < bmin_x_q) bmin_x_q <= cur_x;
							if (cur_x > bmax_x_q) bmax_x_q <= cur_x;
							if (cur_y < bmin_y_q) bmin_y_q <= cur_y;
							if (cur_y > bmax_y_q) bmax_y_q <= cur_y;
						end
					end
				end
				vwta_pkg::ST_FINISH: begin
					done                <= 1'b1;
					result.index_a      <= vwta_pkg::IDX_OUT_W'(idx_q[0]);
					result.index_b      <= vwta_pkg::IDX_OUT_W'(idx_q[1]);
					result.index_c      <= vwta_pkg::IDX_OUT_W'(idx_q[2]);
					result.accepted     <= acc_q;
					result.vertex_count <= vwta_pkg::CNT_OUT_W'(count_q);
					result.box_valid    <= box_valid_q;
					result.box_min_x    <= bmin_x_q;
					result.box_min_y    <= bmin_y_q;
					result.box_max_x    <= bmax_x_q;
					result.box_max_y    <= bmax_y_q;
				end
				default: ;
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done beat while sequencer still busy");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(MAX_VERTICES)) else $error("vertex count reached capacity");

	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en)) else $error("RAM read and write in one cycle");

	a_decide_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vwta_pkg::ST_DECIDE) |-> (!valid_s1 && !valid_s2))
		else $error("decision taken with distance pipeline in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("accepted beat did not raise busy");

endmodule

`default_nettype wire

// ----- tb/vwta_weld_checker.sv -----
// Checker for the weld core: predicts each result from accepted beats and compares it.
`timescale 1ns / 100ps

module vwta_weld_checker #(
	parameter int MAX_VERTICES = vwta_pkg::MAX_VERTICES_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire                        busy,
	input  vwta_pkg::in_beat_t         cmd,
	input  wire                        done,
	input  vwta_pkg::out_beat_t        result,
	input  wire                        cfg_we,
	input  wire [vwta_pkg::WELD_W-1:0] cfg_data,
	output int                         fails,
	output int                         pending
);

	logic [31:0]                 verts [MAX_VERTICES];
	int                          nverts;
	logic                        bb_valid;
	logic signed [15:0]          bb_min_x, bb_min_y, bb_max_x, bb_max_y;
	logic [vwta_pkg::WELD_W-1:0] weld_thr;
	vwta_pkg::out_beat_t         want_results [$];
	int                          nfail = 0;

	assign fails = nfail;

	task automatic flag_bad(input string what, input logic [31:0] got, input logic [31:0] want);
		nfail++;
		$display("weld check %s: got %h want %h at %0t", what, got, want, $time);
	endtask

	// nearest stored vertex, first one on ties; append when not close enough
	function automatic logic [vwta_pkg::IDX_OUT_W-1:0] snap_corner(
			input logic signed [15:0] x, input logic signed [15:0] y);
		int     best;
		longint best_d, d, dx, dy;
		best = 0;
		best_d = 0;
		for (int i = 0; i < nverts; i++) begin
			dx = longint'(x) - longint'($signed(verts[i][15:0]));
			dy = longint'(y) - longint'($signed(verts[i][31:16]));
			d = dx * dx + dy * dy;
			if (i == 0 || d < best_d) begin
				best = i;
				best_d = d;
			end
		end
		if (nverts > 0 && best_d < longint'(weld_thr))
			return best[vwta_pkg::IDX_OUT_W-1:0];
		best = nverts;
		if (best < MAX_VERTICES) begin
			verts[best] = {y, x};
			nverts = best + 1;
		end
		if (!bb_valid) begin
			bb_min_x = x;
			bb_max_x = x;
			bb_min_y = y;
			bb_max_y = y;
			bb_valid = 1'b1;
		end else begin
			if (x < bb_min_x) bb_min_x = x;
			if (x > bb_max_x) bb_max_x = x;
			if (y < bb_min_y) bb_min_y = y;
			if (y > bb_max_y) bb_max_y = y;
		end
		return best[vwta_pkg::IDX_OUT_W-1:0];
	endfunction

	function automatic vwta_pkg::out_beat_t weld_beat(input vwta_pkg::in_beat_t b);
		vwta_pkg::out_beat_t r;
		r = '0;
		if (b.kind == vwta_pkg::KIND_CLEAR) begin
			nverts = 0;
			bb_valid = 1'b0;
			bb_min_x = '0;
			bb_min_y = '0;
			bb_max_x = '0;
			bb_max_y = '0;
			r.accepted = 1'b1;
		end else if (nverts + vwta_pkg::CORNERS < MAX_VERTICES) begin
			r.index_a = snap_corner(b.ax, b.ay);
			r.index_b = snap_corner(b.bx, b.by_coord);
			r.index_c = snap_corner(b.cx, b.cy);
			r.accepted = 1'b1;
		end
		r.vertex_count = nverts[vwta_pkg::CNT_OUT_W-1:0];
		r.box_valid = bb_valid;
		r.box_min_x = bb_min_x;
		r.box_min_y = bb_min_y;
		r.box_max_x = bb_max_x;
		r.box_max_y = bb_max_y;
		return r;
	endfunction

	task automatic match_beat(input vwta_pkg::out_beat_t got);
		vwta_pkg::out_beat_t want;
		if (want_results.size() == 0) begin
			flag_bad("result beat with nothing pending", 32'(got.vertex_count), 32'd0);
			return;
		end
		want = want_results.pop_front();
		if (got.index_a !== want.index_a)
			flag_bad("index_a", 32'(got.index_a), 32'(want.index_a));
		if (got.index_b !== want.index_b)
			flag_bad("index_b", 32'(got.index_b), 32'(want.index_b));
		if (got.index_c !== want.index_c)
			flag_bad("index_c", 32'(got.index_c), 32'(want.index_c));
		if (got.accepted !== want.accepted)
			flag_bad("accepted", 32'(got.accepted), 32'(want.accepted));
		if (got.vertex_count !== want.vertex_count)
			flag_bad("vertex_count", 32'(got.vertex_count), 32'(want.vertex_count));
		if (got.box_valid !== want.box_valid)
			flag_bad("box_valid", 32'(got.box_valid), 32'(want.box_valid));
		if (got.box_min_x !== want.box_min_x)
			flag_bad("box_min_x", 32'(got.box_min_x), 32'(want.box_min_x));
		if (got.box_min_y !== want.box_min_y)
			flag_bad("box_min_y", 32'(got.box_min_y), 32'(want.box_min_y));
		if (got.box_max_x !== want.box_max_x)
			flag_bad("box_max_x", 32'(got.box_max_x), 32'(want.box_max_x));
		if (got.box_max_y !== want.box_max_y)
			flag_bad("box_max_y", 32'(got.box_max_y), 32'(want.box_max_y));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nverts = 0;
			bb_valid = 1'b0;
			bb_min_x = '0;
			bb_min_y = '0;
			bb_max_x = '0;
			bb_max_y = '0;
			weld_thr = vwta_pkg::WELD_RESET;
			want_results.delete();
		end else begin
			if (done === 1'b1)
				match_beat(result);
			if (cfg_we === 1'b1)
				weld_thr = cfg_data;
			if (start === 1'b1 && busy === 1'b0)
				want_results.push_back(weld_beat(cmd));
		end
		pending <= want_results.size();
	end

endmodule

// ----- tb/vertex_weld_triangle_append_core_tb.sv -----
// Testbench top for the weld core: drives command beats and threshold writes, gives the verdict.
`timescale 1ns / 100ps

module vertex_weld_triangle_append_core_tb;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	vwta_pkg::in_beat_t          cmd = '0;
	logic                        done;
	vwta_pkg::out_beat_t         result;
	logic                        cfg_we = 1'b0;
	logic [vwta_pkg::WELD_W-1:0] cfg_data = '0;
	int                          fails;
	int                          pending;
	logic signed [15:0]          recent_x [$];
	logic signed [15:0]          recent_y [$];
	bit                          no_gaps = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	vertex_weld_triangle_append_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	vwta_weld_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.fails    (fails),
		.pending  (pending)
	);

	function automatic int beat_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_beat(input vwta_pkg::in_beat_t b, input int gap);
		bit taken;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= b;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = (busy === 1'b0);
		end
	endtask

	// hold off until every pending result beat has come and the core is idle
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0 || busy !== 1'b0);
	endtask

	task automatic set_weld(input logic [vwta_pkg::WELD_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_tri(input int ax, input int ay, input int bx, input int by,
			input int cx, input int cy);
		vwta_pkg::in_beat_t b;
		b.kind = ~vwta_pkg::KIND_CLEAR;
		b.ax = 16'(ax);
		b.ay = 16'(ay);
		b.bx = 16'(bx);
		b.by_coord = 16'(by);
		b.cx = 16'(cx);
		b.cy = 16'(cy);
		push_beat(b, beat_gap());
	endtask

	task automatic send_clear(input int fill);
		vwta_pkg::in_beat_t b;
		b.kind = vwta_pkg::KIND_CLEAR;
		b.ax = 16'(fill);
		b.ay = 16'(fill);
		b.bx = 16'(fill);
		b.by_coord = 16'(fill);
		b.cx = 16'(fill);
		b.cy = 16'(fill);
		push_beat(b, beat_gap());
	endtask

	// mix of full-range points, points near earlier corners and a tight cluster
	task automatic rand_corner(output logic signed [15:0] x, output logic signed [15:0] y);
		int mode, k, dx, dy;
		mode = $urandom_range(0, 9);
		if (mode < 2 || (mode < 6 && recent_x.size() == 0)) begin
			x = 16'($urandom);
			y = 16'($urandom);
		end else if (mode < 6) begin
			k = int'($urandom_range(0, recent_x.size() - 1));
			dx = int'($urandom_range(0, 40)) - 20;
			dy = int'($urandom_range(0, 40)) - 20;
			x = 16'(recent_x[k] + dx);
			y = 16'(recent_y[k] + dy);
		end else begin
			x = 16'(int'($urandom_range(0, 128)) - 64);
			y = 16'(int'($urandom_range(0, 128)) - 64);
		end
		recent_x.push_back(x);
		recent_y.push_back(y);
		if (recent_x.size() > 48) begin
			recent_x.pop_front();
			recent_y.pop_front();
		end
	endtask

	task automatic rand_item();
		vwta_pkg::in_beat_t b;
		b.kind = ($urandom_range(0, 11) == 0) ? vwta_pkg::KIND_CLEAR : ~vwta_pkg::KIND_CLEAR;
		rand_corner(b.ax, b.ay);
		rand_corner(b.bx, b.by_coord);
		rand_corner(b.cx, b.cy);
		if (b.kind == vwta_pkg::KIND_CLEAR) begin
			recent_x.delete();
			recent_y.delete();
		end
		if ($urandom_range(0, 19) == 0)
			drain();
		push_beat(b, beat_gap());
	endtask

	initial begin
		logic [63:0]                 wide;
		logic [vwta_pkg::WELD_W-1:0] thr;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset threshold, then all-ones, zero and one thresholds: boundary, ties, extremes
		send_tri(0, 0, 0, 0, 16, 0);
		send_tri(8, 0, 0, 15, -32768, -32768);
		send_tri(32767, 32767, 32767, -32768, -32768, 32767);
		send_tri(-32768, -32753, 32767, 32752, 1, -1);
		send_clear(-1);
		send_clear(0);
		send_tri(-1, -1, -1, -1, 0, 0);
		set_weld({vwta_pkg::WELD_W{1'b1}});
		send_tri(32767, 32767, -32768, -32768, 100, -100);
		set_weld('0);
		send_tri(-1, -1, -1, -1, -1, -1);
		send_clear(21845);
		set_weld(34'd1);
		send_tri(5, 5, 5, 5, 6, 5);
		send_tri(6, 6, 4, 5, 21845, -21846);
		set_weld(vwta_pkg::WELD_RESET);
		send_tri(-16, 0, 0, -16, 16, 16);

		// threshold extremes around clears
		set_weld('0);
		send_clear(0);
		set_weld({vwta_pkg::WELD_W{1'b1}});
		send_tri(0, 0, 1, 1, 2, 2);
		send_clear(0);
		send_tri(3, 3, 3, 3, -3, -3);
		send_clear(0);

		for (int ph = 0; ph < 6; ph++) begin
			wide = {$urandom, $urandom};
			case (ph)
				0: thr = vwta_pkg::WELD_RESET;
				1: thr = vwta_pkg::WELD_W'($urandom_range(0, 4096));
				2: thr = wide[vwta_pkg::WELD_W-1:0];
				3: thr = {vwta_pkg::WELD_W{1'b1}};
				4: thr = '0;
				default: thr = vwta_pkg::WELD_W'($urandom_range(1, 300));
			endcase
			set_weld(thr);
			for (int i = 0; i < 28; i++) begin
				no_gaps = (i >= 10 && i < 18);
				rand_item();
			end
			no_gaps = 1'b0;
		end

		drain();
		repeat (200) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
